FILE: hdl/sv39_ptw_pkg.sv
// ----------------------------------------------------------------------------
// Sv39 page-table walker package
// Codes, field widths and the result record shared by the walker and its
// channel interfaces.
// ----------------------------------------------------------------------------
`default_nettype none

package sv39_ptw_pkg;

  localparam int unsigned PPN_W   = 44;
  localparam int unsigned VA_W    = 39;
  localparam int unsigned VPN_W   = 27;
  localparam int unsigned PTE_W   = 64;
  localparam int unsigned PA_W    = 56;
  localparam int unsigned VIDX_W  = 9;

  typedef enum logic {
    ACT_TRANSLATE = 1'b0,
    ACT_PTE       = 1'b1
  } action_t;

  typedef enum logic {
    KIND_READ = 1'b0,
    KIND_DONE = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_TABLE   = 2'd1,
    ST_NOT_MAPPED = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    PAGE_4K = 2'd0,
    PAGE_2M = 2'd1,
    PAGE_1G = 2'd2
  } page_size_t;

  typedef struct packed {
    kind_t             kind;
    logic [PA_W-1:0]   read_addr;
    status_t           status;
    logic [PA_W-1:0]   phys_base;
    logic              can_read;
    logic              can_write;
    logic              can_exec;
    logic              supervisor;
    page_size_t        page_size;
  } result_t;

endpackage

`default_nettype wire

FILE: hdl/sv39_ptw_if.sv
// ----------------------------------------------------------------------------
// Sv39 page-table walker channels
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface sv39_ptw_req_if;
  logic                                    valid;
  logic                                    ready;
  sv39_ptw_pkg::action_t                   action;
  logic [sv39_ptw_pkg::VA_W-1:0]           virt_addr;
  logic [sv39_ptw_pkg::PTE_W-1:0]          pte_data;

  modport source (output valid, action, virt_addr, pte_data, input ready);
  modport sink   (input valid, action, virt_addr, pte_data, output ready);
endinterface

interface sv39_ptw_res_if;
  logic                                    valid;
  logic                                    ready;
  sv39_ptw_pkg::kind_t                     kind;
  logic [sv39_ptw_pkg::PA_W-1:0]           read_addr;
  sv39_ptw_pkg::status_t                   status;
  logic [sv39_ptw_pkg::PA_W-1:0]           phys_base;
  logic                                    can_read;
  logic                                    can_write;
  logic                                    can_exec;
  logic                                    supervisor;
  sv39_ptw_pkg::page_size_t                page_size;

  modport source (output valid, kind, read_addr, status, phys_base, can_read, can_write,
                  can_exec, supervisor, page_size, input ready);
  modport sink   (input valid, kind, read_addr, status, phys_base, can_read, can_write,
                  can_exec, supervisor, page_size, output ready);
endinterface

`default_nettype wire

FILE: hdl/sv39_page_table_walker.sv
// ----------------------------------------------------------------------------
// Sv39 page-table walker
// Three-level walk: issues entry reads and reports the leaf or the fault.
// ----------------------------------------------------------------------------
// The walker takes one item per clock cycle while req is ready. A translate
// request or a returned entry is decoded in the cycle it is accepted; the entry
// address is formed by concatenation, so no adder sits in the path. The result
// item is held in an output register, with a one-item skid stage behind it, so
// req stays ready while a result waits; ready drops only when both are full.
// Requests while a walk is active and entries while idle give no result.
`default_nettype none

module sv39_page_table_walker (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [sv39_ptw_pkg::PPN_W-1:0]      cfg_wdata,
  sv39_ptw_req_if.sink                             req,
  sv39_ptw_res_if.source                           res
);
  import sv39_ptw_pkg::*;

  logic [PPN_W-1:0]  root_table_ppn;
  logic              busy,       busy_next;
  logic [1:0]        walk_level, walk_level_next;
  logic [VPN_W-1:0]  saved_vpn,  saved_vpn_next;

  result_t           out_item;
  logic              out_valid;
  result_t           skid_item;
  logic              skid_valid;

  result_t           result;
  logic              produce;
  logic              accept;
  logic              out_free;

  logic [PPN_W-1:0]  pte_ppn;
  logic              pte_v, pte_r, pte_w, pte_x, pte_u;
  logic [1:0]        level_down;
  logic [VIDX_W-1:0] vidx_down;

  assign accept   = req.valid && req.ready;
  assign req.ready = !skid_valid;
  assign out_free = !out_valid || res.ready;

  assign pte_ppn = req.pte_data[10 +: PPN_W];
  assign pte_v   = req.pte_data[0];
  assign pte_r   = req.pte_data[1];
  assign pte_w   = req.pte_data[2];
  assign pte_x   = req.pte_data[3];
  assign pte_u   = req.pte_data[4];

  assign level_down = (walk_level == 2'd3) ? 2'd1 : walk_level - 2'd1;
  assign vidx_down  = level_down[0] ? saved_vpn[VIDX_W +: VIDX_W]
                                    : saved_vpn[0 +: VIDX_W];

  always_comb begin
    result          = '0;
    result.kind     = KIND_READ;
    result.status   = ST_OK;
    result.page_size = PAGE_4K;
    produce         = 1'b0;
    busy_next       = busy;
    walk_level_next = walk_level;
    saved_vpn_next  = saved_vpn;
    if (accept) begin
      if (req.action == ACT_TRANSLATE) begin
        if (!busy) begin
          produce          = 1'b1;
          busy_next        = 1'b1;
          walk_level_next  = 2'd2;
          saved_vpn_next   = req.virt_addr[VA_W-1:12];
          result.read_addr = {root_table_ppn, req.virt_addr[VA_W-1 -: VIDX_W], 3'b000};
        end
      end else if (busy) begin
        produce = 1'b1;
        if (!pte_v) begin
          busy_next     = 1'b0;
          result.kind   = KIND_DONE;
          result.status = ST_NO_TABLE;
        end else if (pte_r || pte_w || pte_x) begin
          busy_next         = 1'b0;
          result.kind       = KIND_DONE;
          result.phys_base  = {pte_ppn, 12'h000};
          result.can_read   = pte_r;
          result.can_write  = pte_w;
          result.can_exec   = pte_x;
          result.supervisor = !pte_u;
          result.page_size  = (walk_level == 2'd3) ? PAGE_1G : page_size_t'(walk_level);
        end else if (walk_level == 2'd0) begin
          busy_next     = 1'b0;
          result.kind   = KIND_DONE;
          result.status = ST_NOT_MAPPED;
        end else begin
          walk_level_next  = level_down;
          result.read_addr = {pte_ppn, vidx_down, 3'b000};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      root_table_ppn <= '0;
      busy           <= 1'b0;
      walk_level     <= 2'd0;
      saved_vpn      <= '0;
    end else begin
      if (cfg_we) begin
        root_table_ppn <= cfg_wdata;
      end
      busy       <= busy_next;
      walk_level <= walk_level_next;
      saved_vpn  <= saved_vpn_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      out_valid  <= skid_valid || produce;
      skid_valid <= 1'b0;
    end else if (produce) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_item <= skid_valid ? skid_item : result;
    end else if (produce) begin
      skid_item <= result;
    end
  end

  assign res.valid      = out_valid;
  assign res.kind       = out_item.kind;
  assign res.read_addr  = out_item.read_addr;
  assign res.status     = out_item.status;
  assign res.phys_base  = out_item.phys_base;
  assign res.can_read   = out_item.can_read;
  assign res.can_write  = out_item.can_write;
  assign res.can_exec   = out_item.can_exec;
  assign res.supervisor = out_item.supervisor;
  assign res.page_size  = out_item.page_size;

`ifndef SYNTH
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid stage holds an item while the output register is empty");

  a_walk_starts: assert property (@(posedge clk) disable iff (rst)
    (accept && req.action == ACT_TRANSLATE && !busy) |=> (busy && walk_level == 2'd2))
    else $error("accepted translate request did not start a walk");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> walk_level != 2'd3)
    else $error("walk level out of range");

  a_read_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.kind == KIND_READ) |->
      (out_item.status == ST_OK && out_item.phys_base == '0))
    else $error("read request carries finish fields");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !res.ready) |=> $stable(skid_item))
    else $error("skid stage overwritten while stalled");
`endif

endmodule

`default_nettype wire

FILE: tb/sv39_page_table_walker_tb.sv
// ----------------------------------------------------------------------------
// Sv39 page-table walker testbench
// Drives translate requests and returned entries into the walker over its
// valid/ready channels, with random gaps on both sides, and checks every
// read request and walk result against a cycle-free model of the walk held
// in a small scoreboard. Covers the root register at zero, at full scale and
// at random values, plus a long result stall and a full drain mid-run.
// ----------------------------------------------------------------------------
module sv39_page_table_walker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sv39_ptw_pkg::*;

  localparam int unsigned IDLE_LIMIT = 4000;
  localparam int unsigned HOLD_LEN   = 150;
  localparam int unsigned SETTLE_LEN = 8;

  class walk_scoreboard;
    logic [PPN_W-1:0] root_ppn;
    bit               busy;
    logic [1:0]       level;
    logic [VPN_W-1:0] vpn;
    result_t          due[$];
    int               fails;

    function new();
      root_ppn = '0;
      busy     = 1'b0;
      level    = 2'd0;
      vpn      = '0;
      fails    = 0;
    endfunction

    function void set_root(logic [PPN_W-1:0] ppn);
      root_ppn = ppn;
    endfunction

    function int pending();
      return due.size();
    endfunction

    function logic [PA_W-1:0] table_entry(logic [PPN_W-1:0] ppn, logic [1:0] lvl);
      return {ppn, vpn[VIDX_W*lvl +: VIDX_W], 3'b000};
    endfunction

    function void note_input(action_t act, logic [VA_W-1:0] va, logic [PTE_W-1:0] pte);
      result_t          r;
      logic [PPN_W-1:0] ppn;
      r   = '0;
      ppn = pte[53:10];
      if (act == ACT_TRANSLATE) begin
        if (busy) return;
        busy        = 1'b1;
        level       = 2'd2;
        vpn         = va[VA_W-1:12];
        r.kind      = KIND_READ;
        r.read_addr = table_entry(root_ppn, 2'd2);
      end else begin
        if (!busy) return;
        r.kind = KIND_DONE;
        if (!pte[0]) begin
          busy     = 1'b0;
          r.status = ST_NO_TABLE;
        end else if (pte[3:1] != 3'b000) begin
          busy         = 1'b0;
          r.status     = ST_OK;
          r.phys_base  = {ppn, 12'h000};
          r.can_read   = pte[1];
          r.can_write  = pte[2];
          r.can_exec   = pte[3];
          r.supervisor = !pte[4];
          r.page_size  = page_size_t'(level);
        end else if (level == 2'd0) begin
          busy     = 1'b0;
          r.status = ST_NOT_MAPPED;
        end else begin
          level       = level - 2'd1;
          r.kind      = KIND_READ;
          r.read_addr = table_entry(ppn, level);
        end
      end
      due.push_back(r);
    endfunction

    function string show(result_t r);
      return $sformatf("kind=%0d addr=%h st=%0d base=%h r=%b w=%b x=%b s=%b sz=%0d",
                       r.kind, r.read_addr, r.status, r.phys_base, r.can_read,
                       r.can_write, r.can_exec, r.supervisor, r.page_size);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (due.size() == 0) begin
        fails++;
        if (fails <= 10) $display("unexpected result: %s", show(got));
        return;
      end
      want = due.pop_front();
      if (got.kind !== want.kind || got.read_addr !== want.read_addr ||
          got.status !== want.status || got.phys_base !== want.phys_base ||
          got.can_read !== want.can_read || got.can_write !== want.can_write ||
          got.can_exec !== want.can_exec || got.supervisor !== want.supervisor ||
          got.page_size !== want.page_size) begin
        fails++;
        if (fails <= 10) begin
          $display("result mismatch at %0t", $realtime);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we;
  logic [PPN_W-1:0] cfg_wdata;
  bit               no_idle;
  bit               hold_results;
  int unsigned      idle_cycles = 0;
  walk_scoreboard   walks;

  sv39_ptw_req_if req_ch ();
  sv39_ptw_res_if res_ch ();

  sv39_page_table_walker DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .res       (res_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic send_item(action_t act, logic [VA_W-1:0] va, logic [PTE_W-1:0] pte);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.action    <= act;
    req_ch.virt_addr <= va;
    req_ch.pte_data  <= pte;
    do @(posedge clk); while (!req_ch.ready);
    walks.note_input(act, va, pte);
  endtask

  task automatic settle();
    req_ch.valid <= 1'b0;
    while (walks.pending() != 0) @(posedge clk);
    repeat (SETTLE_LEN) @(posedge clk);
  endtask

  task automatic write_root(logic [PPN_W-1:0] ppn);
    cfg_we    <= 1'b1;
    cfg_wdata <= ppn;
    @(posedge clk);
    cfg_we    <= 1'b0;
    walks.set_root(ppn);
  endtask

  function automatic logic [VA_W-1:0] random_va();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[VA_W-1:0];
  endfunction

  function automatic logic [PTE_W-1:0] random_pte(logic [1:0] lvl);
    logic [PTE_W-1:0] pte;
    int               roll;
    int               leaf_pct;
    pte      = {$urandom, $urandom};
    roll     = $urandom_range(0, 99);
    leaf_pct = (lvl == 2'd2) ? 30 : (lvl == 2'd1) ? 40 : 70;
    pte[0]   = (roll >= 10);
    if (roll >= 10 && roll < 10 + leaf_pct) pte[3:1] = 3'($urandom_range(1, 7));
    else if (roll >= 10) pte[3:1] = 3'b000;
    return pte;
  endfunction

  task automatic run_directed();
    send_item(ACT_TRANSLATE, 39'h7F_FFFF_FFFF, 64'h0);
    send_item(ACT_TRANSLATE, 39'h00_0000_0000, 64'h0);
    send_item(ACT_PTE, 39'h0, 64'hFFFF_FFFF_FFFF_FFF1);
    send_item(ACT_PTE, 39'h0, 64'h0000_0000_0000_0001);
    send_item(ACT_PTE, 39'h0, 64'h0000_0000_0000_0001);
    send_item(ACT_PTE, 39'h0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(ACT_TRANSLATE, 39'h00_0000_0000, 64'h0);
    send_item(ACT_PTE, 39'h0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(ACT_TRANSLATE, 39'h55_5555_5555, 64'h0);
    send_item(ACT_PTE, 39'h0, 64'h0000_0000_0000_0000);
    send_item(ACT_TRANSLATE, 39'h2A_AAAA_AAAA, 64'h0);
    send_item(ACT_PTE, 39'h0, 64'h0000_0000_1234_5401);
    send_item(ACT_PTE, 39'h0, 64'h003F_FFFF_FFFF_FC03);
    send_item(ACT_TRANSLATE, 39'h12_3456_789A, 64'h0);
    send_item(ACT_PTE, 39'h0, 64'h0000_0000_0ABC_D001);
    send_item(ACT_PTE, 39'h0, 64'h0000_0000_0000_4001);
    send_item(ACT_PTE, 39'h0, 64'h0000_0000_0000_8019);
    send_item(ACT_TRANSLATE, 39'h7F_FFFF_F000, 64'h0);
    send_item(ACT_PTE, 39'h0, 64'h0000_0000_0000_0001);
    send_item(ACT_PTE, 39'h0, 64'hFFFF_FFFF_FFFF_FFFE);
    send_item(ACT_TRANSLATE, 39'h00_0000_0FFF, 64'h0);
    send_item(ACT_PTE, 39'h0, 64'h0000_0000_0000_0001);
    send_item(ACT_PTE, 39'h0, 64'h0000_0000_0000_0001);
    send_item(ACT_PTE, 39'h0, 64'h0000_0000_0000_0002);
    send_item(ACT_TRANSLATE, 39'h40_0000_0000, 64'h0);
    send_item(ACT_PTE, 39'h0, 64'hC000_0000_0000_0005);
  endtask

  task automatic run_walks(int n, bit stall_mid, bit drain_mid);
    int count;
    bit noise;
    count = 0;
    while (count < n) begin
      noise = ($urandom_range(0, 99) < 8);
      if (walks.busy ^ noise) send_item(ACT_PTE, random_va(), random_pte(walks.level));
      else send_item(ACT_TRANSLATE, random_va(), {$urandom, $urandom});
      if (!noise) count++;
      if (count == n / 2 && !noise) begin
        if (stall_mid) hold_results = 1'b1;
        if (drain_mid) settle();
      end
    end
    if (walks.busy) send_item(ACT_PTE, random_va(), 64'h0);
    settle();
  endtask

  initial begin
    int wait_cycles;
    walks            = new();
    req_ch.valid     <= 1'b0;
    req_ch.action    <= ACT_TRANSLATE;
    req_ch.virt_addr <= '0;
    req_ch.pte_data  <= '0;
    cfg_we           <= 1'b0;
    cfg_wdata        <= '0;
    no_idle          = 1'b0;
    hold_results     = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_root({PPN_W{1'b1}});
    run_directed();
    settle();
    write_root('0);
    run_walks(115, 1'b1, 1'b0);
    write_root(PPN_W'({$urandom, $urandom}));
    run_walks(115, 1'b0, 1'b1);
    write_root({PPN_W{1'b1}});
    no_idle = 1'b1;
    run_walks(50, 1'b0, 1'b0);
    no_idle = 1'b0;
    run_walks(60, 1'b0, 1'b0);
    write_root(PPN_W'({$urandom, $urandom}));
    run_walks(115, 1'b0, 1'b0);
    write_root(PPN_W'({$urandom, $urandom}));
    run_walks(115, 1'b0, 1'b0);

    req_ch.valid <= 1'b0;
    wait_cycles = 0;
    while (walks.pending() != 0 && wait_cycles < 2000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (10) @(posedge clk);
    if (walks.pending() != 0) $display("results missing: %0d", walks.pending());
    if (walks.fails == 0 && walks.pending() == 0) begin
      $display("sv39_page_table_walker verification clean");
    end else begin
      $display("sv39_page_table_walker verification failed");
    end
    $finish;
  end

  initial begin
    int unsigned gap;
    res_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_results) begin
        res_ch.ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
        hold_results = 1'b0;
      end
      gap = no_idle ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid);
    end
  end

  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      walks.check_result(result_t'{res_ch.kind, res_ch.read_addr, res_ch.status,
                                   res_ch.phys_base, res_ch.can_read, res_ch.can_write,
                                   res_ch.can_exec, res_ch.supervisor, res_ch.page_size});
    end
    if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
      $display("sv39_page_table_walker verification failed");
      $finish;
    end
  end

endmodule
